/* sv/rrts_pkg.sv */
// shared types and constants of the round-robin task scheduler
package rrts_pkg;

	localparam int MAX_TASKS = 16;
	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam int ID_W = 16;
	localparam int QTIME_W = 32;
	localparam int SLEEP_W = 22;
	localparam int UNITS_W = 16;
	localparam int QUANT_W = 8;
	localparam int CFG_ADDR_W = 1;
	localparam int IN_W = 40;
	localparam int OUT_W = 72;

	localparam logic [ID_W-1:0] ID_LAST = '1;
	localparam logic [CFG_ADDR_W-1:0] CFG_SHORT_QUANTUM = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_LONG_QUANTUM = 1'd1;
	localparam logic [QUANT_W-1:0] SHORT_QUANTUM_RST = 8'd10;
	localparam logic [QUANT_W-1:0] LONG_QUANTUM_RST = 8'd20;

	typedef enum logic [2:0] {
		OP_CREATE, OP_REMOVE, OP_TICK, OP_SUSPEND,
		OP_WAKE, OP_FINISH, OP_DISPATCH, OP_QUERY
	} op_t;

	typedef enum logic [1:0] {
		TS_READY, TS_RUNNING, TS_WAITING, TS_TERMINATED
	} tstate_t;

	typedef enum logic [1:0] {
		STS_OK, STS_MISS, STS_IDLE_WAIT, STS_EMPTY
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE, FSM_SCAN, FSM_ROTATE, FSM_FINISH
	} fsm_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		tstate_t            st;
		logic               lng;
		logic [QTIME_W-1:0] queued;
		logic [SLEEP_W-1:0] sleep;
	} cell_t;

	// broadcast command from the sequencer to every cell
	typedef struct packed {
		logic [CNT_W-1:0]   total;
		logic               shift_en;
		logic [CNT_W-1:0]   shift_lo;
		logic [CNT_W-1:0]   shift_hi;
		logic               load_en;
		logic [IDX_W-1:0]   load_idx;
		cell_t              load_data;
		logic               tick_en;
		logic [QUANT_W-1:0] quantum;
		logic               st_en;
		logic [IDX_W-1:0]   st_idx;
		tstate_t            st_val;
		logic               slp_en;
		logic [SLEEP_W-1:0] slp_val;
		logic               wake_en;
		logic [ID_W-1:0]    wake_id;
	} cell_cmd_t;

endpackage

/* sv/rrts_cell.sv */
// one list position of the scheduler: a task slot that can take its right neighbor
module rrts_cell (
	input  logic                     clk,
	input  logic [rrts_pkg::IDX_W-1:0] idx,
	input  rrts_pkg::cell_cmd_t      cmd,
	input  rrts_pkg::cell_t          right,
	output rrts_pkg::cell_t          cell_q
);
	import rrts_pkg::*;

	logic               live;
	logic               in_shift;
	logic [QTIME_W:0]   qsum;
	cell_t              nxt;

	assign live = {1'b0, idx} < cmd.total;
	assign in_shift = ({1'b0, idx} >= cmd.shift_lo) && ({1'b0, idx} < cmd.shift_hi);
	assign qsum = {1'b0, cell_q.queued} + {{(QTIME_W + 1 - QUANT_W){1'b0}}, cmd.quantum};

	always_comb begin
		nxt = cell_q;
		if (cmd.load_en && cmd.load_idx == idx) begin
			nxt = cmd.load_data;
		end else if (cmd.shift_en && in_shift) begin
			nxt = right;
		end else begin
			if (cmd.st_en && cmd.st_idx == idx) begin
				nxt.st = cmd.st_val;
				if (cmd.slp_en) begin
					nxt.sleep = cmd.slp_val;
				end
			end
			if (cmd.tick_en && live) begin
				case (cell_q.st)
					TS_READY: begin
						nxt.queued = qsum[QTIME_W] ? '1 : qsum[QTIME_W-1:0];
					end
					TS_WAITING: begin
						// wake once the remaining sleep is used up
						if (cell_q.sleep <= {{(SLEEP_W - QUANT_W){1'b0}}, cmd.quantum}) begin
							nxt.st = TS_READY;
							nxt.sleep = '0;
						end else begin
							nxt.sleep = cell_q.sleep
								- {{(SLEEP_W - QUANT_W){1'b0}}, cmd.quantum};
						end
					end
					default: ;
				endcase
			end
			if (cmd.wake_en && live && cell_q.id == cmd.wake_id
				&& cell_q.st == TS_WAITING) begin
				nxt.st = TS_READY;
				nxt.sleep = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cell_q <= nxt;
	end

endmodule

/* sv/round_robin_task_scheduler.sv */
// round-robin task scheduler: sequencer over a chain of task cells
// create, wake and finish pass from idle straight to the finish state, tick by way of the
// rotate state; remove, query, suspend and dispatch scan the list one position a cycle;
// one event is in flight at a time
// the next input transfer is taken while a finished result waits on the output
// arst_n clears control, counters and the current selection; cells need no reset
module round_robin_task_scheduler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rrts_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [rrts_pkg::QUANT_W-1:0]    cfg_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// operation[2:0], task_id[18:3], long_quantum[19], sleep_units[35:20], zero fill
	input  logic [rrts_pkg::IN_W-1:0]       s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// status[1:0], current_valid[2], current_id[18:3], current_is_long[19],
	// created_id[35:20], task_state[37:36], queue_time[69:38], zero fill
	output logic [rrts_pkg::OUT_W-1:0]      m_axis_tdata
);
	import rrts_pkg::*;

	// cell chain
	cell_cmd_t cmd;
	cell_t     cells [MAX_TASKS];

	genvar g;
	generate
		for (g = 0; g < MAX_TASKS; g++) begin : g_cell
			if (g == MAX_TASKS - 1) begin : g_last
				rrts_cell u_cell (
					.clk    (clk),
					.idx    (IDX_W'(g)),
					.cmd    (cmd),
					.right  ('0),
					.cell_q (cells[g])
				);
			end else begin : g_mid
				rrts_cell u_cell (
					.clk    (clk),
					.idx    (IDX_W'(g)),
					.cmd    (cmd),
					.right  (cells[g+1]),
					.cell_q (cells[g])
				);
			end
		end
	endgenerate

	// sequencer state
	fsm_t               fsm_q, fsm_d;
	op_t                op_q, op_d;
	logic [ID_W-1:0]    id_q, id_d;
	status_t            status_q, status_d;
	logic [ID_W-1:0]    created_q, created_d;
	tstate_t            qstate_q, qstate_d;
	logic [QTIME_W-1:0] qtime_q, qtime_d;
	logic [CNT_W-1:0]   scan_q, scan_d;
	logic [IDX_W-1:0]   cand_q, cand_d;
	logic               run_f_q, run_f_d, rdy_f_q, rdy_f_d, wt_f_q, wt_f_d;
	logic [IDX_W-1:0]   run_pos_q, run_pos_d, rdy_pos_q, rdy_pos_d, wt_pos_q, wt_pos_d;
	logic [CNT_W-1:0]   total_q, total_d;
	logic [ID_W-1:0]    idc_q, idc_d;
	logic [IDX_W-1:0]   cur_q, cur_d;
	logic               cur_set_q, cur_set_d;
	logic [QUANT_W-1:0] short_q, long_q;
	logic               out_valid_q, out_valid_d;
	logic [OUT_W-1:0]   out_data_q, out_data_d;

	// input fields
	op_t                in_op;
	logic [ID_W-1:0]    in_id;
	logic               in_lq;
	logic [UNITS_W-1:0] in_units;

	assign in_op = op_t'(s_axis_tdata[2:0]);
	assign in_id = s_axis_tdata[18:3];
	assign in_lq = s_axis_tdata[19];
	assign in_units = s_axis_tdata[35:20];

	cell_t              cur_cell, scan_cell, cand_cell, rot_cell;
	logic               cur_eff;
	logic               accept;
	logic               scan_done;
	logic [MAX_TASKS-1:0] wake_hits;
	logic [IDX_W-1:0]   cur_next, cand_next;
	logic [CNT_W-1:0]   total_m1;
	logic               cur_valid;

	assign cur_cell = cells[cur_q];
	assign scan_cell = cells[scan_q[IDX_W-1:0]];
	assign cand_cell = cells[cand_q];
	assign cur_eff = cur_set_q && ({1'b0, cur_q} < total_q);
	assign accept = s_axis_tvalid && fsm_q == FSM_IDLE;
	assign scan_done = scan_q >= total_q;
	assign total_m1 = total_q - 1'b1;
	// neighbor after a position, wrapping at the list length
	assign cur_next = ({1'b0, cur_q} + 1'b1 == total_q) ? '0 : cur_q + 1'b1;
	assign cand_next = ({1'b0, cand_q} + 1'b1 == total_q) ? '0 : cand_q + 1'b1;
	assign cur_valid = cur_set_q && ({1'b0, cur_q} < total_q);

	always_comb begin
		rot_cell = cur_cell;
		rot_cell.st = TS_READY;
	end

	// waiting tasks that a wake would hit
	always_comb begin
		for (int i = 0; i < MAX_TASKS; i++) begin
			wake_hits[i] = (CNT_W'(i) < total_q) && cells[i].id == in_id
				&& cells[i].st == TS_WAITING;
		end
	end

	always_comb begin
		fsm_d = fsm_q;
		op_d = op_q;
		id_d = id_q;
		status_d = status_q;
		created_d = created_q;
		qstate_d = qstate_q;
		qtime_d = qtime_q;
		scan_d = scan_q;
		cand_d = cand_q;
		run_f_d = run_f_q;
		rdy_f_d = rdy_f_q;
		wt_f_d = wt_f_q;
		run_pos_d = run_pos_q;
		rdy_pos_d = rdy_pos_q;
		wt_pos_d = wt_pos_q;
		total_d = total_q;
		idc_d = idc_q;
		cur_d = cur_q;
		cur_set_d = cur_set_q;
		out_valid_d = out_valid_q;
		out_data_d = out_data_q;

		cmd = '0;
		cmd.total = total_q;
		cmd.wake_id = in_id;

		if (out_valid_q && m_axis_tready) begin
			out_valid_d = 1'b0;
		end

		case (fsm_q)
			FSM_IDLE: begin
				if (accept) begin
					op_d = in_op;
					id_d = in_id;
					status_d = STS_OK;
					created_d = '0;
					qstate_d = TS_READY;
					qtime_d = '0;
					cur_set_d = cur_eff;
					scan_d = '0;
					run_f_d = 1'b0;
					rdy_f_d = 1'b0;
					wt_f_d = 1'b0;
					fsm_d = FSM_FINISH;
					case (in_op)
						OP_CREATE: begin
							if (total_q == CNT_W'(MAX_TASKS) || idc_q == ID_LAST) begin
								status_d = STS_MISS;
							end else begin
								idc_d = idc_q + 1'b1;
								created_d = idc_q + 1'b1;
								cmd.load_en = 1'b1;
								cmd.load_idx = total_q[IDX_W-1:0];
								cmd.load_data.id = idc_q + 1'b1;
								cmd.load_data.st = TS_READY;
								cmd.load_data.lng = in_lq;
								total_d = total_q + 1'b1;
							end
						end
						OP_REMOVE, OP_QUERY, OP_DISPATCH: begin
							fsm_d = FSM_SCAN;
						end
						OP_TICK: begin
							if (cur_eff) begin
								cmd.tick_en = 1'b1;
								cmd.quantum = cur_cell.lng ? long_q : short_q;
								fsm_d = FSM_ROTATE;
							end
						end
						OP_SUSPEND: begin
							if (!cur_eff || cur_cell.st != TS_RUNNING) begin
								status_d = STS_MISS;
							end else begin
								cmd.st_en = 1'b1;
								cmd.st_idx = cur_q;
								cmd.st_val = TS_WAITING;
								cmd.slp_en = 1'b1;
								// units * 10 as two shifted copies
								cmd.slp_val = SLEEP_W'({in_units, 3'b000})
									+ SLEEP_W'({in_units, 1'b0});
								status_d = STS_IDLE_WAIT;
								scan_d = CNT_W'(1);
								cand_d = cur_next;
								fsm_d = FSM_SCAN;
							end
						end
						OP_WAKE: begin
							cmd.wake_en = 1'b1;
							status_d = (|wake_hits) ? STS_OK : STS_MISS;
						end
						OP_FINISH: begin
							if (!cur_eff) begin
								status_d = STS_MISS;
							end else begin
								cmd.st_en = 1'b1;
								cmd.st_idx = cur_q;
								cmd.st_val = TS_TERMINATED;
							end
						end
						default: ;
					endcase
				end
			end
			FSM_SCAN: begin
				case (op_q)
					OP_REMOVE, OP_QUERY: begin
						if (scan_done) begin
							status_d = STS_MISS;
							fsm_d = FSM_FINISH;
						end else if (scan_cell.id == id_q) begin
							fsm_d = FSM_FINISH;
							if (op_q == OP_REMOVE) begin
								cmd.shift_en = 1'b1;
								cmd.shift_lo = scan_q;
								cmd.shift_hi = total_m1;
								total_d = total_m1;
								if (cur_set_q) begin
									if ({1'b0, cur_q} == scan_q) begin
										cur_set_d = 1'b0;
									end else if ({1'b0, cur_q} > scan_q) begin
										cur_d = cur_q - 1'b1;
									end
								end
							end else begin
								qstate_d = scan_cell.st;
								qtime_d = scan_cell.queued;
							end
						end else begin
							scan_d = scan_q + 1'b1;
						end
					end
					OP_SUSPEND: begin
						if (scan_done) begin
							fsm_d = FSM_FINISH;
						end else if (cand_cell.st == TS_READY) begin
							cmd.st_en = 1'b1;
							cmd.st_idx = cand_q;
							cmd.st_val = TS_RUNNING;
							cur_d = cand_q;
							status_d = STS_OK;
							fsm_d = FSM_FINISH;
						end else begin
							scan_d = scan_q + 1'b1;
							cand_d = cand_next;
						end
					end
					OP_DISPATCH: begin
						if (scan_done) begin
							fsm_d = FSM_FINISH;
							if (run_f_q) begin
								cur_d = run_pos_q;
								cur_set_d = 1'b1;
							end else if (rdy_f_q) begin
								cmd.st_en = 1'b1;
								cmd.st_idx = rdy_pos_q;
								cmd.st_val = TS_RUNNING;
								cur_d = rdy_pos_q;
								cur_set_d = 1'b1;
							end else if (wt_f_q) begin
								cur_d = wt_pos_q;
								cur_set_d = 1'b1;
								status_d = STS_IDLE_WAIT;
							end else begin
								cur_set_d = 1'b0;
								status_d = STS_EMPTY;
							end
						end else begin
							scan_d = scan_q + 1'b1;
							// keep the first running, ready and waiting position
							case (scan_cell.st)
								TS_RUNNING: begin
									if (!run_f_q) begin
										run_f_d = 1'b1;
										run_pos_d = scan_q[IDX_W-1:0];
									end
								end
								TS_READY: begin
									if (!rdy_f_q) begin
										rdy_f_d = 1'b1;
										rdy_pos_d = scan_q[IDX_W-1:0];
									end
								end
								TS_WAITING: begin
									if (!wt_f_q) begin
										wt_f_d = 1'b1;
										wt_pos_d = scan_q[IDX_W-1:0];
									end
								end
								default: ;
							endcase
						end
					end
					default: begin
						fsm_d = FSM_FINISH;
					end
				endcase
			end
			FSM_ROTATE: begin
				// running task goes back to ready at the tail of the list
				if (cur_cell.st == TS_RUNNING) begin
					cmd.load_en = 1'b1;
					cmd.load_idx = total_m1[IDX_W-1:0];
					cmd.load_data = rot_cell;
					cmd.shift_en = 1'b1;
					cmd.shift_lo = {1'b0, cur_q};
					cmd.shift_hi = total_m1;
					cur_d = total_m1[IDX_W-1:0];
				end
				fsm_d = FSM_FINISH;
			end
			FSM_FINISH: begin
				if (!out_valid_q || m_axis_tready) begin
					out_valid_d = 1'b1;
					out_data_d = '0;
					out_data_d[1:0] = status_q;
					out_data_d[2] = cur_valid;
					out_data_d[18:3] = cur_valid ? cur_cell.id : '0;
					out_data_d[19] = cur_valid ? cur_cell.lng : 1'b0;
					out_data_d[35:20] = created_q;
					out_data_d[37:36] = qstate_q;
					out_data_d[69:38] = qtime_q;
					fsm_d = FSM_IDLE;
				end
			end
			default: begin
				fsm_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= FSM_IDLE;
			total_q <= '0;
			idc_q <= '0;
			cur_q <= '0;
			cur_set_q <= 1'b0;
			out_valid_q <= 1'b0;
			short_q <= SHORT_QUANTUM_RST;
			long_q <= LONG_QUANTUM_RST;
		end else begin
			fsm_q <= fsm_d;
			total_q <= total_d;
			idc_q <= idc_d;
			cur_q <= cur_d;
			cur_set_q <= cur_set_d;
			out_valid_q <= out_valid_d;
			if (cfg_we) begin
				case (cfg_addr)
					CFG_SHORT_QUANTUM: short_q <= cfg_data;
					CFG_LONG_QUANTUM:  long_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// event payload and scan bookkeeping
	always_ff @(posedge clk) begin
		op_q <= op_d;
		id_q <= id_d;
		status_q <= status_d;
		created_q <= created_d;
		qstate_q <= qstate_d;
		qtime_q <= qtime_d;
		scan_q <= scan_d;
		cand_q <= cand_d;
		run_f_q <= run_f_d;
		rdy_f_q <= rdy_f_d;
		wt_f_q <= wt_f_d;
		run_pos_q <= run_pos_d;
		rdy_pos_q <= rdy_pos_d;
		wt_pos_q <= wt_pos_d;
		out_data_q <= out_data_d;
	end

	assign s_axis_tready = (fsm_q == FSM_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

endmodule

/* sv/rrts_checker.sv */
// port-level checks of the scheduler and their binding
module rrts_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [rrts_pkg::OUT_W-1:0]      m_axis_tdata
);
	import rrts_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// no selection shows no id
	a_noid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[19:3] == '0)
		else $error("id shown without a current task");

	// no task left leaves no selection
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == STS_EMPTY |-> !m_axis_tdata[2])
		else $error("selection with no task left");

	// a created id comes with ok status
	a_create: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[35:20] != '0 |-> m_axis_tdata[1:0] == STS_OK)
		else $error("created id with failing status");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

/* verif/tb_top.sv */
// self-checking testbench of the round-robin task scheduler
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rrts_pkg::*;

	localparam int MAX_MISMATCH_SHOWN = 10;
	localparam longint CYCLE_LIMIT = 400000;

	// one scheduler event as it travels on the input stream
	typedef struct packed {
		logic [UNITS_W-1:0] sleep_units;
		logic               long_quantum;
		logic [ID_W-1:0]    task_id;
		op_t                operation;
	} event_t;

	// one scheduler answer as it travels on the output stream
	typedef struct packed {
		logic [QTIME_W-1:0] queue_time;
		tstate_t            task_state;
		logic [ID_W-1:0]    created_id;
		logic               current_is_long;
		logic [ID_W-1:0]    current_id;
		logic               current_valid;
		status_t            status;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [QUANT_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	round_robin_task_scheduler i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow copy of the scheduler state
	logic [QUANT_W-1:0]  sh_short_q, sh_long_q;
	logic [IDX_W-1:0]    sh_order [MAX_TASKS];
	int unsigned         sh_total;
	logic [ID_W-1:0]     sh_id [MAX_TASKS];
	tstate_t             sh_state [MAX_TASKS];
	logic                sh_long [MAX_TASKS];
	logic [QTIME_W-1:0]  sh_queued [MAX_TASKS];
	logic [31:0]         sh_sleep [MAX_TASKS];
	logic [ID_W-1:0]     sh_id_counter;
	int unsigned         sh_cur_pos;
	bit                  sh_cur_set;

	event_t  pending_events [$];
	answer_t expected_answers [$];
	int unsigned mismatches, answers_seen, events_sent;
	int unsigned op_hits [8];
	longint cycles;
	bit idle_free;
	bit drain_done;

	function automatic int unsigned find_task(logic [ID_W-1:0] id);
		for (int unsigned p = 0; p < sh_total; p++)
			if (sh_id[sh_order[p]] == id)
				return p;
		return sh_total;
	endfunction

	function automatic int unsigned first_slot_free();
		bit used;
		for (int unsigned s = 0; s < MAX_TASKS; s++) begin
			used = 1'b0;
			for (int unsigned p = 0; p < sh_total; p++)
				if (sh_order[p] == s)
					used = 1'b1;
			if (!used)
				return s;
		end
		return 0;
	endfunction

	function automatic bit first_in(tstate_t st, output int unsigned pos);
		pos = 0;
		for (int unsigned p = 0; p < sh_total; p++)
			if (sh_state[sh_order[p]] == st) begin
				pos = p;
				return 1'b1;
			end
		return 1'b0;
	endfunction

	// advance the shadow scheduler by one event and return its answer
	function automatic answer_t schedule_event(event_t ev);
		answer_t a;
		int unsigned p, s, cs, cand;
		logic [QUANT_W-1:0] q;
		logic [32:0] sum;
		a = '0;
		a.status = STS_OK;
		a.task_state = TS_READY;
		if (sh_cur_set && sh_cur_pos >= sh_total)
			sh_cur_set = 1'b0;
		case (ev.operation)
			OP_CREATE: begin
				if (sh_total >= MAX_TASKS || sh_id_counter == ID_LAST) begin
					a.status = STS_MISS;
				end else begin
					s = first_slot_free();
					sh_id_counter = sh_id_counter + 1'b1;
					sh_id[s] = sh_id_counter;
					sh_state[s] = TS_READY;
					sh_long[s] = ev.long_quantum;
					sh_queued[s] = '0;
					sh_sleep[s] = '0;
					sh_order[sh_total] = s[IDX_W-1:0];
					sh_total++;
					a.created_id = sh_id_counter;
				end
			end
			OP_REMOVE: begin
				p = find_task(ev.task_id);
				if (p >= sh_total) begin
					a.status = STS_MISS;
				end else begin
					if (sh_cur_set) begin
						if (sh_cur_pos == p)
							sh_cur_set = 1'b0;
						else if (sh_cur_pos > p)
							sh_cur_pos--;
					end
					for (; p + 1 < sh_total; p++)
						sh_order[p] = sh_order[p+1];
					sh_total--;
				end
			end
			OP_TICK: begin
				if (sh_cur_set) begin
					cs = sh_order[sh_cur_pos];
					q = sh_long[cs] ? sh_long_q : sh_short_q;
					for (p = 0; p < sh_total; p++) begin
						s = sh_order[p];
						if (sh_state[s] == TS_READY) begin
							sum = {1'b0, sh_queued[s]} + q;
							sh_queued[s] = sum[32] ? '1 : sum[31:0];
						end else if (sh_state[s] == TS_WAITING) begin
							if (sh_sleep[s] <= q) begin
								sh_state[s] = TS_READY;
								sh_sleep[s] = '0;
							end else begin
								sh_sleep[s] = sh_sleep[s] - q;
							end
						end
					end
					// running task rotates to the tail
					if (sh_state[cs] == TS_RUNNING) begin
						sh_state[cs] = TS_READY;
						for (p = sh_cur_pos; p + 1 < sh_total; p++)
							sh_order[p] = sh_order[p+1];
						sh_order[sh_total-1] = cs[IDX_W-1:0];
						sh_cur_pos = sh_total - 1;
					end
				end
			end
			OP_SUSPEND: begin
				if (!sh_cur_set || sh_state[sh_order[sh_cur_pos]] != TS_RUNNING) begin
					a.status = STS_MISS;
				end else begin
					cs = sh_order[sh_cur_pos];
					sh_state[cs] = TS_WAITING;
					sh_sleep[cs] = ev.sleep_units * 32'd10;
					a.status = STS_IDLE_WAIT;
					// next ready task after the current one, wrapping
					for (p = 1; p < sh_total; p++) begin
						cand = (sh_cur_pos + p) % sh_total;
						s = sh_order[cand];
						if (sh_state[s] == TS_READY) begin
							sh_state[s] = TS_RUNNING;
							sh_cur_pos = cand;
							a.status = STS_OK;
							break;
						end
					end
				end
			end
			OP_WAKE: begin
				a.status = STS_MISS;
				for (p = 0; p < sh_total; p++) begin
					s = sh_order[p];
					if (sh_id[s] == ev.task_id && sh_state[s] == TS_WAITING) begin
						sh_state[s] = TS_READY;
						sh_sleep[s] = '0;
						a.status = STS_OK;
					end
				end
			end
			OP_FINISH: begin
				if (!sh_cur_set)
					a.status = STS_MISS;
				else
					sh_state[sh_order[sh_cur_pos]] = TS_TERMINATED;
			end
			OP_DISPATCH: begin
				if (first_in(TS_RUNNING, p)) begin
					sh_cur_pos = p;
					sh_cur_set = 1'b1;
				end else if (first_in(TS_READY, p)) begin
					sh_state[sh_order[p]] = TS_RUNNING;
					sh_cur_pos = p;
					sh_cur_set = 1'b1;
				end else if (first_in(TS_WAITING, p)) begin
					sh_cur_pos = p;
					sh_cur_set = 1'b1;
					a.status = STS_IDLE_WAIT;
				end else begin
					sh_cur_set = 1'b0;
					a.status = STS_EMPTY;
				end
			end
			default: begin
				p = find_task(ev.task_id);
				if (p >= sh_total) begin
					a.status = STS_MISS;
				end else begin
					a.task_state = sh_state[sh_order[p]];
					a.queue_time = sh_queued[sh_order[p]];
				end
			end
		endcase
		if (sh_cur_set && sh_cur_pos < sh_total) begin
			cs = sh_order[sh_cur_pos];
			a.current_valid = 1'b1;
			a.current_id = sh_id[cs];
			a.current_is_long = sh_long[cs];
		end
		return a;
	endfunction

	// id picker: mostly live ids, sometimes near ones or any value
	function automatic logic [ID_W-1:0] pick_id();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70 && sh_total > 0)
			return sh_id[sh_order[$urandom_range(sh_total-1)]];
		if (r < 90)
			return ID_W'($urandom_range(sh_id_counter + 2));
		return ID_W'($urandom);
	endfunction

	// build an event, predict it, queue it for the driver
	task automatic post_event(op_t op, logic [ID_W-1:0] id, logic lq,
			logic [UNITS_W-1:0] units);
		event_t ev;
		ev.operation = op;
		ev.task_id = id;
		ev.long_quantum = lq;
		ev.sleep_units = units;
		op_hits[op]++;
		expected_answers.push_back(schedule_event(ev));
		pending_events.push_back(ev);
	endtask

	task automatic wait_drained();
		while (pending_events.size() != 0 || expected_answers.size() != 0)
			@(posedge clk);
		// idle margin after the last answer before the next phase
		repeat (MAX_TASKS + 8) @(posedge clk);
	endtask

	// one register write, a one-cycle enable strobe, dropped again before returning
	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [QUANT_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_SHORT_QUANTUM)
			sh_short_q = val;
		else
			sh_long_q = val;
	endtask

	// driver: present the oldest pending event, idle at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (s_axis_tvalid)
					events_sent++;
				if (s_axis_tvalid && pending_events.size() != 0)
					void'(pending_events.pop_front());
				if (pending_events.size() > (s_axis_tvalid ? 1 : 0) - (s_axis_tvalid ? 1 : 0)
						&& (idle_free || $urandom_range(99) >= 26)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= IN_W'(pending_events[0]);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= idle_free || ($urandom_range(99) >= 26);
		end
	end

	// monitor: compare each answer transfer with the oldest prediction
	always @(posedge clk) begin
		answer_t got, want;
		cycles++;
		if (m_axis_tvalid && m_axis_tready) begin
			got = answer_t'(m_axis_tdata[$bits(answer_t)-1:0]);
			answers_seen++;
			if (expected_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_MISMATCH_SHOWN)
					$display("unexpected answer %h", got);
			end else begin
				want = expected_answers.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_MISMATCH_SHOWN)
						$display("answer %0d mismatch: expected %p actual %p",
							answers_seen, want, got);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d answers outstanding", expected_answers.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// random phase: mostly well-formed scheduling traffic
	task automatic random_events(int unsigned count);
		int unsigned r;
		op_t op;
		for (int unsigned k = 0; k < count; k++) begin
			r = $urandom_range(99);
			if (sh_total < 3 && r < 40)       op = OP_CREATE;
			else if (r < 14)                  op = OP_CREATE;
			else if (r < 22)                  op = OP_REMOVE;
			else if (r < 42)                  op = OP_TICK;
			else if (r < 54)                  op = OP_SUSPEND;
			else if (r < 64)                  op = OP_WAKE;
			else if (r < 70)                  op = OP_FINISH;
			else if (r < 86)                  op = OP_DISPATCH;
			else                              op = OP_QUERY;
			post_event(op, pick_id(), 1'($urandom),
				($urandom_range(9) == 0) ? UNITS_W'($urandom) :
				UNITS_W'($urandom_range(6)));
		end
	endtask

	initial begin
		sh_short_q = SHORT_QUANTUM_RST;
		sh_long_q = LONG_QUANTUM_RST;
		sh_total = 0;
		sh_id_counter = '0;
		sh_cur_pos = 0;
		sh_cur_set = 1'b0;
		mismatches = 0;
		answers_seen = 0;
		events_sent = 0;
		cycles = 0;
		idle_free = 1'b0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			sh_order[i] = '0; sh_id[i] = '0; sh_state[i] = TS_READY;
			sh_long[i] = 1'b0; sh_queued[i] = '0; sh_sleep[i] = '0;
		end
		foreach (op_hits[i]) op_hits[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-list corner cases
		post_event(OP_TICK, '0, 1'b0, '0);
		post_event(OP_SUSPEND, '0, 1'b0, '0);
		post_event(OP_FINISH, '0, 1'b0, '0);
		post_event(OP_DISPATCH, '0, 1'b0, '0);
		post_event(OP_QUERY, '1, 1'b1, '1);
		post_event(OP_REMOVE, 16'h5a5a, 1'b0, '0);
		post_event(OP_WAKE, '1, 1'b0, '0);
		// a short and a long task, run, rotate, sleep, wake
		post_event(OP_CREATE, '0, 1'b0, '0);
		post_event(OP_CREATE, '1, 1'b1, '1);
		post_event(OP_DISPATCH, '0, 1'b0, '0);
		post_event(OP_TICK, '0, 1'b0, '0);
		post_event(OP_DISPATCH, '0, 1'b0, '0);
		post_event(OP_SUSPEND, '0, 1'b0, '1);
		post_event(OP_SUSPEND, '0, 1'b0, 16'd1);
		post_event(OP_DISPATCH, '0, 1'b0, '0);
		post_event(OP_WAKE, 16'd2, 1'b0, '0);
		post_event(OP_QUERY, 16'd1, 1'b0, '0);
		post_event(OP_DISPATCH, '0, 1'b0, '0);
		post_event(OP_FINISH, '0, 1'b0, '0);
		post_event(OP_QUERY, 16'd1, 1'b0, '0);
		post_event(OP_REMOVE, 16'd1, 1'b0, '0);
		// fill to overflow
		for (int i = 0; i < MAX_TASKS; i++)
			post_event(OP_CREATE, '0, 1'(i), '0);
		post_event(OP_QUERY, 16'd3, 1'b0, '0);
		wait_drained();

		// extreme quanta, then random traffic under several settings
		write_reg(CFG_SHORT_QUANTUM, 8'd255);
		write_reg(CFG_LONG_QUANTUM, 8'd1);
		random_events(200);
		wait_drained();
		write_reg(CFG_SHORT_QUANTUM, 8'd1);
		write_reg(CFG_LONG_QUANTUM, 8'd255);
		idle_free = 1'b1;
		random_events(200);
		wait_drained();
		idle_free = 1'b0;
		write_reg(CFG_SHORT_QUANTUM, '0);
		write_reg(CFG_LONG_QUANTUM, 8'(1 + $urandom_range(253)));
		random_events(200);
		wait_drained();
		write_reg(CFG_SHORT_QUANTUM, 8'(1 + $urandom_range(254)));
		write_reg(CFG_LONG_QUANTUM, '0);
		random_events(250);
		wait_drained();

		$display("covered %0d events: create %0d remove %0d tick %0d suspend %0d",
			events_sent, op_hits[OP_CREATE], op_hits[OP_REMOVE], op_hits[OP_TICK],
			op_hits[OP_SUSPEND]);
		$display("wake %0d finish %0d dispatch %0d query %0d, quanta 0 to 255",
			op_hits[OP_WAKE], op_hits[OP_FINISH], op_hits[OP_DISPATCH], op_hits[OP_QUERY]);
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
